>>> hw/rtl/stick_cartesian_to_polar_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stick Cartesian-to-polar unit
// Expect clk and rst in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef STICK_CARTESIAN_TO_POLAR_UNIT_MACROS_SVH
`define STICK_CARTESIAN_TO_POLAR_UNIT_MACROS_SVH

// Same-cycle implication.
`define SCPU_ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scpu: same-cycle check failed");

// Next-cycle implication.
`define SCPU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scpu: next-cycle check failed");

`endif

>>> hw/rtl/scpu_pkg.sv
// ----------------------------------------------------------------------------
// scpu_pkg
// Types, constants and the arctangent table shared by the unit.
// ----------------------------------------------------------------------------
package scpu_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int ATAN_LEN   = 24;
  localparam int CORDIC_RUN = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int SQRT_STEPS = 16;
  localparam int ITER_COUNT = (CORDIC_RUN > SQRT_STEPS) ? CORDIC_RUN : SQRT_STEPS;
  localparam int STEP_W     = $clog2(ATAN_LEN);

  // x and y carry 16 fraction bits below the Q1.14 input plus CORDIC growth
  localparam int CORDIC_W   = 35;
  localparam int ROUND_BIT  = 31 - ANGLE_BITS;
  localparam int ANGLE_DOWN = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int ANGLE_UP   = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

  localparam logic [14:0] MAG_MAX = 15'h7FFF;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  typedef struct packed {
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
  } stick_in_t;

  typedef struct packed {
    logic [14:0] left_magnitude;
    logic [15:0] left_angle;
    logic [14:0] right_magnitude;
    logic [15:0] right_angle;
  } stick_out_t;

  typedef struct packed {
    logic              load;
    logic              sum;
    logic              step;
    logic              publish;
    logic [STEP_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // atan(2^-i) in turns, scaled to 2^32
  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [31:0] t;
    case (i)
      5'd0:    t = 32'd536870912;
      5'd1:    t = 32'd316933406;
      5'd2:    t = 32'd167458907;
      5'd3:    t = 32'd85004756;
      5'd4:    t = 32'd42667331;
      5'd5:    t = 32'd21354465;
      5'd6:    t = 32'd10679838;
      5'd7:    t = 32'd5340245;
      5'd8:    t = 32'd2670163;
      5'd9:    t = 32'd1335087;
      5'd10:   t = 32'd667544;
      5'd11:   t = 32'd333772;
      5'd12:   t = 32'd166886;
      5'd13:   t = 32'd83443;
      5'd14:   t = 32'd41722;
      5'd15:   t = 32'd20861;
      5'd16:   t = 32'd10430;
      5'd17:   t = 32'd5215;
      5'd18:   t = 32'd2608;
      5'd19:   t = 32'd1304;
      5'd20:   t = 32'd652;
      5'd21:   t = 32'd326;
      5'd22:   t = 32'd163;
      5'd23:   t = 32'd81;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

>>> hw/rtl/scpu_stick.sv
// ----------------------------------------------------------------------------
// scpu_stick
// One stick lane: squares, bit-serial square root and iterative CORDIC
// vectoring, plus the held angle for a centered stick.
// ----------------------------------------------------------------------------
`include "stick_cartesian_to_polar_unit_macros.svh"

module scpu_stick (
  input  logic                clk,
  input  logic                rst,
  input  scpu_pkg::cmd_t      cmd,
  input  logic signed [15:0]  x,
  input  logic signed [15:0]  y,
  output logic [14:0]         magnitude,
  output logic [15:0]         angle
);

  logic [30:0]                          sq_x;
  logic [30:0]                          sq_y;
  logic [31:0]                          s;
  logic [19:0]                          rem;
  logic [15:0]                          root;
  logic signed [scpu_pkg::CORDIC_W-1:0] cx;
  logic signed [scpu_pkg::CORDIC_W-1:0] cy;
  logic [31:0]                          z;
  logic [15:0]                          held;
  logic                                 centered;

  logic signed [31:0]                   prod_x;
  logic signed [31:0]                   prod_y;
  logic signed [scpu_pkg::CORDIC_W-1:0] xe;
  logic signed [scpu_pkg::CORDIC_W-1:0] ye;
  logic signed [scpu_pkg::CORDIC_W-1:0] dx;
  logic signed [scpu_pkg::CORDIC_W-1:0] dy;
  logic [31:0]                          t;
  logic                                 cordic_on;
  logic                                 sqrt_on;
  logic [19:0]                          rem_t;
  logic [19:0]                          trial;
  logic [16:0]                          root_r;
  logic [32:0]                          zr;
  logic [scpu_pkg::ANGLE_BITS-1:0]      q;
  logic [23:0]                          q24;
  logic [23:0]                          ang_wide;
  logic [15:0]                          ang_calc;

  always_comb begin
    prod_x    = 32'(x) * 32'(x);
    prod_y    = 32'(y) * 32'(y);
    xe        = {{3{x[15]}}, x, 16'h0000};
    ye        = {{3{y[15]}}, y, 16'h0000};
    dx        = cy >>> cmd.idx;
    dy        = cx >>> cmd.idx;
    t         = scpu_pkg::atan_turn(cmd.idx);
    cordic_on = cmd.idx < scpu_pkg::STEP_W'(scpu_pkg::CORDIC_RUN);
    sqrt_on   = cmd.idx < scpu_pkg::STEP_W'(scpu_pkg::SQRT_STEPS);
    rem_t     = {rem[17:0], s[31:30]};
    trial     = {2'b00, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sq_x     <= prod_x[30:0];
      sq_y     <= prod_y[30:0];
      centered <= (x == 16'sd0) && (y == 16'sd0);
      // fold the left half plane onto the right one
      if (x[15]) begin
        cx <= -xe;
        cy <= -ye;
        z  <= scpu_pkg::HALF_TURN;
      end else begin
        cx <= xe;
        cy <= ye;
        z  <= 32'h0;
      end
    end
    if (cmd.sum) begin
      s    <= {1'b0, sq_x} + {1'b0, sq_y};
      rem  <= '0;
      root <= '0;
    end
    if (cmd.step && cordic_on) begin
      if (!cy[scpu_pkg::CORDIC_W-1]) begin
        cx <= cx + dx;
        cy <= cy - dy;
        z  <= z + t;
      end else begin
        cx <= cx - dx;
        cy <= cy + dy;
        z  <= z - t;
      end
    end
    if (cmd.step && sqrt_on) begin
      s <= {s[29:0], 2'b00};
      if (rem_t >= trial) begin
        rem  <= rem_t - trial;
        root <= {root[14:0], 1'b1};
      end else begin
        rem  <= rem_t;
        root <= {root[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (cmd.publish && !centered) begin
      held <= ang_calc;
    end
  end

  always_comb begin
    // round to nearest: remainder above root means the upper neighbor is closer
    root_r    = {1'b0, root} + 17'(rem > {4'b0000, root});
    magnitude = (root_r > {2'b00, scpu_pkg::MAG_MAX}) ? scpu_pkg::MAG_MAX : root_r[14:0];
    zr        = {1'b0, z} + (33'd1 << scpu_pkg::ROUND_BIT);
    q         = zr[31 -: scpu_pkg::ANGLE_BITS];
    q24       = 24'(q);
    ang_wide  = (q24 >> scpu_pkg::ANGLE_DOWN) << scpu_pkg::ANGLE_UP;
    ang_calc  = ang_wide[15:0];
    angle     = centered ? held : ang_calc;
  end

  `SCPU_ASSERT_NEXT(a_root_rem_bound, cmd.step && sqrt_on, rem <= {3'b000, root, 1'b0})
  `SCPU_ASSERT_NEXT(a_centered_keeps_held, cmd.publish && centered, $stable(held))

endmodule

>>> hw/rtl/scpu_datapath.sv
// ----------------------------------------------------------------------------
// scpu_datapath
// Two stick lanes and the result register toward the output channel.
// ----------------------------------------------------------------------------
module scpu_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  scpu_pkg::cmd_t        cmd,
  output scpu_pkg::status_t     status,
  input  scpu_pkg::stick_in_t   req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output scpu_pkg::stick_out_t  rsp
);

  logic [14:0] left_mag;
  logic [15:0] left_ang;
  logic [14:0] right_mag;
  logic [15:0] right_ang;

  scpu_stick u_left (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .x         (req.left_x),
    .y         (req.left_y),
    .magnitude (left_mag),
    .angle     (left_ang)
  );

  scpu_stick u_right (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .x         (req.right_x),
    .y         (req.right_y),
    .magnitude (right_mag),
    .angle     (right_ang)
  );

  assign status.out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.publish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      rsp.left_magnitude  <= left_mag;
      rsp.left_angle      <= left_ang;
      rsp.right_magnitude <= right_mag;
      rsp.right_angle     <= right_ang;
    end
  end

endmodule

>>> hw/rtl/scpu_ctrl.sv
// ----------------------------------------------------------------------------
// scpu_ctrl
// Sequencer: capture, sum of squares, shared iteration count, publish.
// ----------------------------------------------------------------------------
`include "stick_cartesian_to_polar_unit_macros.svh"

module scpu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output scpu_pkg::cmd_t     cmd,
  input  scpu_pkg::status_t  status
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_ITER = 4'b0100,
    ST_SEND = 4'b1000
  } state_t;

  state_t                      state;
  state_t                      state_next;
  logic [scpu_pkg::STEP_W-1:0] cnt;
  logic                        last_step;

  assign last_step = cnt == scpu_pkg::STEP_W'(scpu_pkg::ITER_COUNT - 1);
  assign req_stall = state != ST_IDLE;

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.sum     = 1'b0;
    cmd.step    = 1'b0;
    cmd.publish = 1'b0;
    cmd.idx     = cnt;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_ITER;
      end
      ST_ITER: begin
        cmd.step = 1'b1;
        if (last_step) begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        // hold until the result register can take the transaction
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (cmd.step) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  `SCPU_ASSERT_HOLDS(a_publish_when_free, cmd.publish, status.out_free)
  `SCPU_ASSERT_NEXT(a_accept_then_busy, req_valid && !req_stall, req_stall)

endmodule

>>> hw/rtl/stick_cartesian_to_polar_unit.sv
// ----------------------------------------------------------------------------
// stick_cartesian_to_polar_unit
// Converts both analog sticks from Q1.14 (x, y) to radius and binary angle.
// ----------------------------------------------------------------------------
// A transaction runs from acceptance to a result in the output register as
// follows: the squares are registered at the accepting edge, the sum state adds
// them, ITER_COUNT = 16 iterations follow, and the send state rounds into the
// result register. The iterations run the CORDIC vectoring stage and one root
// bit of the square root per cycle in each stick lane. One transaction is in
// flight at a time; the next is accepted in the cycle after the result is
// loaded. A result still waiting on the output holds the following one in its
// last step until the output register frees up. A centered stick repeats its
// last angle, which is 0 after reset.
module stick_cartesian_to_polar_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  scpu_pkg::stick_in_t   req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output scpu_pkg::stick_out_t  rsp
);

  scpu_pkg::cmd_t    cmd;
  scpu_pkg::status_t status;

  scpu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .status    (status)
  );

  scpu_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
